FILE: hw/rtl/maf_pkg.sv
package maf_pkg;

  // History depth of the filter; a power of two so the ring address wraps naturally.
  localparam int HIST_DEPTH = 32;
  localparam int HIST_AW    = $clog2(HIST_DEPTH);

  localparam int SAMPLE_W = 16;
  localparam int WIN_W    = 6;
  localparam int CFG_W    = 8;
  localparam int SUM_W    = 21;
  localparam int DIV_CW   = $clog2(SUM_W);

  // Queue between the front and the back.
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic        [WIN_W-1:0]    win_t;
  typedef logic signed [SUM_W-1:0]    sum_t;

  localparam win_t WIN_RESET = win_t'(HIST_DEPTH);

  typedef struct packed {
    sample_t sample;
    win_t    win;
  } q_entry_t;

  typedef struct packed {
    logic           full;
    logic           empty;
    logic [QAW:0]   cnt;
  } q_stat_t;

  // A zero window acts as one sample; anything past the history depth is clamped.
  function automatic win_t eff_window(input win_t w);
    win_t r;
    if (w == '0) begin
      r = win_t'(1);
    end else if (w > win_t'(HIST_DEPTH)) begin
      r = win_t'(HIST_DEPTH);
    end else begin
      r = w;
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/moving_average_filter.sv
// The back end handles one sample at a time: it reads one history entry per cycle to
// form the sum and then divides one bit a cycle, while the queue holds later samples.
// Reset (rst_n, synchronous, active low) clears the history valid flags, so the history
// reads as zero, sets the write position to zero, empties the queue and sets window_length to 32.
module moving_average_filter (
  input  logic                     clk,
  input  logic                     rst_n,
  // Configuration: bits [5:0] window_length, bits [7:6] zero.
  input  logic                     cfg_tvalid,
  output logic                     cfg_tready,
  input  logic [maf_pkg::CFG_W-1:0] cfg_tdata,
  // Input request: bits [15:0] sample.
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [15:0]              in_tdata,
  // Result: bits [15:0] average.
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [15:0]              out_tdata
);

  // The window length register. Writes are only expected while the filter is idle,
  // so the port always takes them.
  maf_pkg::win_t     win_len_r;
  maf_pkg::q_stat_t  q_stat;
  maf_pkg::q_entry_t q_din;
  maf_pkg::q_entry_t q_dout;
  logic              q_push;
  logic              q_pop;
  maf_pkg::sample_t  out_avg;

  assign cfg_tready = 1'b1;
  assign out_tdata  = out_avg;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_len_r <= maf_pkg::WIN_RESET;
    end else if (cfg_tvalid && cfg_tready) begin
      win_len_r <= cfg_tdata[maf_pkg::WIN_W-1:0];
    end
  end

  // The front takes each request into a holding register and tags it with the
  // clamped window length, so a zero length acts as one sample.
  maf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .win_len   (win_len_r),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_din     (q_din)
  );

  // A short queue decouples the front from the back so new requests keep
  // arriving while the back is still summing or dividing.
  maf_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .pop   (q_pop),
    .dout  (q_dout),
    .stat  (q_stat)
  );

  // The back writes the sample into the history ring, sums the newest entries
  // one per cycle, divides the magnitude serially and restores the sign, which
  // gives truncation toward zero. Its output register lets it start the next
  // request while a finished average is still waiting.
  maf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .q_dout     (q_dout),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_avg)
  );

`ifndef SYNTHESIS
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.cnt <= (maf_pkg::QAW+1)'(maf_pkg::QDEPTH))
    else $error("queue count beyond its depth");

  a_pop_ok: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("back end popped an empty queue");

  a_push_ok: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("front end pushed into a full queue");
`endif

endmodule

FILE: hw/rtl/maf_front.sv
module maf_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  maf_pkg::sample_t  in_tdata,
  input  maf_pkg::win_t     win_len,
  input  maf_pkg::q_stat_t  q_stat,
  output logic              q_push,
  output maf_pkg::q_entry_t q_din
);

  logic              vld_r;
  logic              vld_nxt;
  maf_pkg::q_entry_t ent_r;
  logic              take;

  // The request is tagged with the clamped window that was in force when it arrived.
  assign q_push    = vld_r && !q_stat.full;
  assign in_tready = !vld_r || !q_stat.full;
  assign take      = in_tvalid && in_tready;
  assign q_din     = ent_r;

  always_comb begin
    vld_nxt = vld_r;
    if (take) begin
      vld_nxt = 1'b1;
    end else if (q_push) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      ent_r.sample <= in_tdata;
      ent_r.win    <= maf_pkg::eff_window(win_len);
    end
  end

endmodule

FILE: hw/rtl/maf_queue.sv
module maf_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  maf_pkg::q_entry_t din,
  input  logic              pop,
  output maf_pkg::q_entry_t dout,
  output maf_pkg::q_stat_t  stat
);

  maf_pkg::q_entry_t             slot_r [maf_pkg::QDEPTH];
  logic [maf_pkg::QAW-1:0]       wr_ptr_r;
  logic [maf_pkg::QAW-1:0]       wr_ptr_nxt;
  logic [maf_pkg::QAW-1:0]       rd_ptr_r;
  logic [maf_pkg::QAW-1:0]       rd_ptr_nxt;
  logic [maf_pkg::QAW:0]         cnt_r;
  logic [maf_pkg::QAW:0]         cnt_nxt;

  assign stat.full  = (cnt_r == (maf_pkg::QAW+1)'(maf_pkg::QDEPTH));
  assign stat.empty = (cnt_r == '0);
  assign stat.cnt   = cnt_r;
  assign dout       = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= din;
    end
  end

endmodule

FILE: hw/rtl/maf_back.sv
module maf_back (
  input  logic              clk,
  input  logic              rst_n,
  input  maf_pkg::q_stat_t  q_stat,
  input  maf_pkg::q_entry_t q_dout,
  output logic              q_pop,
  output logic              out_tvalid,
  input  logic              out_tready,
  output maf_pkg::sample_t  out_tdata
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_WRITE,
    S_SUM,
    S_DIV,
    S_DONE
  } state_t;

  localparam int SW = maf_pkg::SAMPLE_W;
  localparam int WW = maf_pkg::WIN_W;
  localparam int UW = maf_pkg::SUM_W;
  localparam int AW = maf_pkg::HIST_AW;

  state_t                state_r, state_nxt;
  logic [AW-1:0]         pos_r, pos_nxt;
  maf_pkg::sample_t      smp_r, smp_nxt;
  maf_pkg::win_t         win_r, win_nxt;
  maf_pkg::win_t         iss_r, iss_nxt;
  logic                  pend_r, pend_nxt;
  maf_pkg::sum_t         acc_r, acc_nxt;
  logic                  neg_r, neg_nxt;
  logic [UW-1:0]         dvd_r, dvd_nxt;
  logic [WW-1:0]         rem_r, rem_nxt;
  logic [maf_pkg::DIV_CW-1:0] stp_r, stp_nxt;
  logic                  out_vld_r, out_vld_nxt;
  maf_pkg::sample_t      out_dat_r, out_dat_nxt;

  // History ring: data in a memory, a valid flag per entry so unwritten slots read zero.
  maf_pkg::sample_t      hist_mem [maf_pkg::HIST_DEPTH];
  logic [maf_pkg::HIST_DEPTH-1:0] valid_r;
  maf_pkg::sample_t      rd_dat_r;
  logic                  rd_ok_r;

  logic [AW-1:0]         rd_addr;
  logic                  rd_en;
  logic                  wr_en;
  maf_pkg::sum_t         add_val;
  logic [WW:0]           rem_sh;
  logic                  ge;
  logic [WW:0]           rem_sub;
  logic [UW-1:0]         quot_s;

  assign rd_addr = pos_r - iss_r[AW-1:0];
  assign rd_en   = (state_r == S_SUM) && (iss_r < win_r);
  assign wr_en   = (state_r == S_WRITE);
  assign add_val = rd_ok_r ? UW'(rd_dat_r) : '0;

  // One quotient bit per cycle, restoring form.
  assign rem_sh  = {rem_r, dvd_r[UW-1]};
  assign ge      = (rem_sh >= {1'b0, win_r});
  assign rem_sub = rem_sh - {1'b0, win_r};
  assign quot_s  = neg_r ? (~dvd_r + 1'b1) : dvd_r;

  assign q_pop      = (state_r == S_IDLE) && !q_stat.empty;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_dat_r;

  always_comb begin
    state_nxt   = state_r;
    pos_nxt     = pos_r;
    smp_nxt     = smp_r;
    win_nxt     = win_r;
    iss_nxt     = iss_r;
    pend_nxt    = pend_r;
    acc_nxt     = acc_r;
    neg_nxt     = neg_r;
    dvd_nxt     = dvd_r;
    rem_nxt     = rem_r;
    stp_nxt     = stp_r;
    out_vld_nxt = out_vld_r;
    out_dat_nxt = out_dat_r;

    if (out_vld_r && out_tready) begin
      out_vld_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (!q_stat.empty) begin
          smp_nxt   = q_dout.sample;
          win_nxt   = q_dout.win;
          state_nxt = S_WRITE;
        end
      end
      S_WRITE: begin
        iss_nxt   = '0;
        pend_nxt  = 1'b0;
        acc_nxt   = '0;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        pend_nxt = rd_en;
        if (rd_en) begin
          iss_nxt = iss_r + 1'b1;
        end
        if (pend_r) begin
          acc_nxt = acc_r + add_val;
        end
        if (!rd_en && !pend_r) begin
          neg_nxt   = acc_r[UW-1];
          dvd_nxt   = acc_r[UW-1] ? UW'(-acc_r) : UW'(acc_r);
          rem_nxt   = '0;
          stp_nxt   = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        dvd_nxt = {dvd_r[UW-2:0], ge};
        rem_nxt = ge ? rem_sub[WW-1:0] : rem_sh[WW-1:0];
        stp_nxt = stp_r + 1'b1;
        if (stp_r == maf_pkg::DIV_CW'(UW-1)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_vld_r || out_tready) begin
          out_vld_nxt = 1'b1;
          out_dat_nxt = quot_s[SW-1:0];
          pos_nxt     = pos_r + 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      pos_r     <= '0;
      out_vld_r <= 1'b0;
      valid_r   <= '0;
      rd_ok_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      pos_r     <= pos_nxt;
      out_vld_r <= out_vld_nxt;
      rd_ok_r   <= valid_r[rd_addr];
      if (wr_en) begin
        valid_r[pos_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    smp_r     <= smp_nxt;
    win_r     <= win_nxt;
    iss_r     <= iss_nxt;
    pend_r    <= pend_nxt;
    acc_r     <= acc_nxt;
    neg_r     <= neg_nxt;
    dvd_r     <= dvd_nxt;
    rem_r     <= rem_nxt;
    stp_r     <= stp_nxt;
    out_dat_r <= out_dat_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      hist_mem[pos_r] <= smp_r;
    end
    rd_dat_r <= hist_mem[rd_addr];
  end

endmodule

FILE: tb/sv/moving_average_filter_test.sv
module moving_average_filter_test;
  import maf_pkg::*;

  // A run of this many cycles in which no channel moves a request means the block hung.
  localparam int STALL_LIMIT = 3000;
  // Number of random samples after the directed part.
  localparam int RANDOM_SAMPLES = 600;
  // Cycles allowed after the last average for any stray output to show up.
  localparam int SETTLE_CYCLES = 80;

  // Value patterns that one random phase draws its samples from.
  typedef enum int {
    PAT_UNIFORM,
    PAT_EXTREME,
    PAT_NEAR_ZERO,
    PAT_STEADY
  } pattern_t;

  // Running model of the filter: the sample ring, its write position and the window
  // register, plus the averages that have been predicted but not yet seen.
  class maf_scoreboard;
    sample_t     ring[HIST_DEPTH];
    int unsigned wr_pos;
    win_t        window_reg;
    sample_t     average_q[$];

    function new();
      foreach (ring[i]) ring[i] = '0;
      wr_pos     = 0;
      window_reg = win_t'(HIST_DEPTH);
    endfunction

    function void set_window(input win_t w);
      window_reg = w;
    endfunction

    // Zero acts as a single sample and anything past the ring depth is clamped.
    function int span();
      int n;
      n = int'(window_reg);
      if (n == 0) n = 1;
      if (n > HIST_DEPTH) n = HIST_DEPTH;
      return n;
    endfunction

    function void note_sample(input sample_t s);
      int total;
      int n;
      n = span();
      total = 0;
      ring[wr_pos] = s;
      for (int k = 0; k < n; k++) begin
        total += int'(ring[(wr_pos + HIST_DEPTH - k) % HIST_DEPTH]);
      end
      wr_pos = (wr_pos + 1) % HIST_DEPTH;
      // Signed integer division truncates toward zero, as the filter does.
      average_q.push_back(sample_t'(total / n));
    endfunction

    function int pending();
      return average_q.size();
    endfunction

    function bit check_average(input sample_t got, output sample_t want, output bit orphan);
      orphan = 1'b0;
      want   = '0;
      if (average_q.size() == 0) begin
        orphan = 1'b1;
        return 1'b0;
      end
      want = average_q.pop_front();
      return got === want;
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_tvalid;
  logic              cfg_tready;
  logic [CFG_W-1:0]  cfg_tdata;   // [5:0] window_length, [7:6] zero
  logic              in_tvalid;
  logic              in_tready;
  logic [15:0]       in_tdata;    // [15:0] sample
  logic              out_tvalid;
  logic              out_tready;
  logic [15:0]       out_tdata;   // [15:0] average

  maf_scoreboard sb;
  int            mismatches = 0;
  int            idle_cycles;
  // When set, the matching side runs without gaps for a while.
  bit            in_quiet;
  bit            out_quiet;

  moving_average_filter u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_tvalid (cfg_tvalid),
    .cfg_tready (cfg_tready),
    .cfg_tdata  (cfg_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    mismatches++;
  endtask

  // Drives one sample request. Inputs move only on the falling edge; the request is
  // taken at the first rising edge where valid and ready are both high. Valid stays
  // high between back-to-back samples so a zero gap never drops it for a cycle.
  task automatic send_sample(input sample_t s);
    int gap;
    gap = in_quiet ? 0 : $urandom_range(0, 10);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  = s;
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    sb.note_sample(s);
  endtask

  // Stops sending and waits until every predicted average has come back, so the
  // block is idle before the window register is touched.
  task automatic hold_until_drained();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Writes window_length through the configuration channel. Only called while idle.
  task automatic write_window(input win_t w);
    @(negedge clk);
    cfg_tdata  = CFG_W'(w);
    cfg_tvalid = 1'b1;
    do @(posedge clk); while (!cfg_tready);
    sb.set_window(w);
    @(negedge clk);
    cfg_tvalid = 1'b0;
  endtask

  function automatic sample_t draw_sample(input pattern_t pat, input sample_t steady);
    sample_t s;
    case (pat)
      PAT_EXTREME: begin
        case ($urandom_range(0, 3))
          0: s = sample_t'(16'sh7FFF);
          1: s = sample_t'(16'sh8000);
          2: s = sample_t'(-1);
          default: s = sample_t'($urandom);
        endcase
      end
      PAT_NEAR_ZERO: s = sample_t'($urandom_range(0, 16) - 8);
      PAT_STEADY: s = ($urandom_range(0, 7) == 0) ? sample_t'($urandom) : steady;
      default: s = sample_t'($urandom);
    endcase
    return s;
  endfunction

  // Result side: takes averages with random stalls and checks each against the oldest
  // prediction. Quiet stretches come and go so back-pressure hits every phase.
  initial begin
    sample_t want;
    bit      orphan;
    int      gap;
    out_tready = 1'b0;
    out_quiet  = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if ($urandom_range(0, 29) == 0) out_quiet = !out_quiet;
      gap = out_quiet ? 0 : $urandom_range(0, 10);
      @(negedge clk);
      if (gap > 0) begin
        out_tready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
      if (!sb.check_average(sample_t'(out_tdata), want, orphan)) begin
        if (orphan) begin
          report_mismatch($sformatf("average %0d with no sample pending",
                                    sample_t'(out_tdata)));
        end else begin
          report_mismatch($sformatf("average %0d, expected %0d",
                                    sample_t'(out_tdata), want));
        end
      end
    end
  end

  // Watchdog: any accepted request on any channel restarts the count.
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_tvalid && cfg_tready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    int       sent;
    int       phase;
    int       phase_len;
    win_t     win;
    pattern_t pat;
    sample_t  steady;

    rst_n       = 1'b0;
    cfg_tvalid  = 1'b0;
    cfg_tdata   = '0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_quiet    = 1'b0;
    sb          = new();
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // Reset window of 32: the first averages blend the samples with the zeroed ring.
    send_sample(sample_t'(16'sh7FFF));
    send_sample(sample_t'(16'sh8000));
    send_sample(sample_t'(-1));
    send_sample(sample_t'(1));
    send_sample(sample_t'(16'sh5555));
    send_sample(sample_t'(16'shAAAA));

    // A zero window behaves as a window of one, so each average is the sample itself.
    hold_until_drained();
    write_window(win_t'(0));
    send_sample(sample_t'(16'sh8000));
    send_sample(sample_t'(16'sh7FFF));
    send_sample(sample_t'(-3));

    // A window past the ring depth is clamped to the full depth.
    hold_until_drained();
    write_window(win_t'(33));
    send_sample(sample_t'(16'sh8000));
    send_sample(sample_t'(16'sh8000));
    send_sample(sample_t'(16'sh7FFF));

    // Window of two: odd negative sums check truncation toward zero, and the first
    // average under the new length picks up the history written under the old one.
    hold_until_drained();
    write_window(win_t'(2));
    send_sample(sample_t'(-1));
    send_sample(sample_t'(0));
    send_sample(sample_t'(-3));
    send_sample(sample_t'(0));
    send_sample(sample_t'(-4));

    // Random phases, each with its own window, value pattern and gap behavior. The
    // first few windows cover the extremes of the register.
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_SAMPLES) begin
      case (phase)
        0: win = win_t'(63);
        1: win = win_t'(1);
        2: win = win_t'(0);
        3: win = win_t'(HIST_DEPTH);
        default: win = win_t'($urandom_range(0, 63));
      endcase
      hold_until_drained();
      write_window(win);
      pat       = pattern_t'($urandom_range(0, 3));
      steady    = sample_t'($urandom);
      phase_len = $urandom_range(10, 60);
      in_quiet  = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < phase_len && sent < RANDOM_SAMPLES; i++) begin
        // Now and then the sender waits for the filter to empty mid-phase.
        if ($urandom_range(0, 99) == 0) hold_until_drained();
        send_sample(draw_sample(pat, steady));
        sent++;
      end
      phase++;
    end

    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/maf_pkg.sv
hw/rtl/maf_front.sv
hw/rtl/maf_queue.sv
hw/rtl/maf_back.sv
hw/rtl/moving_average_filter.sv
tb/sv/moving_average_filter_test.sv
